// ===== rtl/qbr_pkg.sv =====
package qbr_pkg;

    localparam int IO_W           = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam int ACC_W          = 64;

    typedef logic signed [IO_W-1:0] coord_t;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    typedef enum logic [2:0] {
        RS_PIXEL    = 3'd0,
        RS_END      = 3'd1,
        RS_ABORT    = 3'd2,
        RS_STRAIGHT = 3'd3,
        RS_STARTED  = 3'd4,
        RS_IDLE     = 3'd5
    } status_t;

    // datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NOP,
        OP_IDLE_STEP,
        OP_LOAD,
        OP_MUL_XEY,
        OP_MUL_YEX,
        OP_MUL_EXX,
        OP_MUL_EYY,
        OP_MUL_XXX,
        OP_MUL_YYY,
        OP_SUM_Y,
        OP_ORIENT,
        OP_MUL_XY,
        OP_MUL_XS,
        OP_MUL_YS,
        OP_MUL_CVX,
        OP_MUL_CVY,
        OP_DY,
        OP_FINISH,
        OP_STRAIGHT,
        OP_STEP_A,
        OP_STEP_B
    } dp_op_t;

    typedef struct packed {
        logic active;
        logic cv_zero;
        logic at_stop;
    } dp_stat_t;

endpackage

// ===== rtl/qbr_in_if.sv =====
interface qbr_in_if;
    logic              valid;
    logic              ready;
    logic              func;
    qbr_pkg::coord_t   start_x;
    qbr_pkg::coord_t   start_y;
    qbr_pkg::coord_t   ctrl_x;
    qbr_pkg::coord_t   ctrl_y;
    qbr_pkg::coord_t   end_x;
    qbr_pkg::coord_t   end_y;

    modport source (
        output valid, func, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, func, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
        output ready
    );
endinterface

// ===== rtl/qbr_out_if.sv =====
interface qbr_out_if;
    logic              valid;
    logic              ready;
    qbr_pkg::coord_t   pixel_x;
    qbr_pkg::coord_t   pixel_y;
    logic [2:0]        status;

    modport source (
        output valid, pixel_x, pixel_y, status,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, status,
        output ready
    );
endinterface

// ===== rtl/qbr_ctrl.sv =====
module qbr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_func,
    input  logic              out_free,
    input  qbr_pkg::dp_stat_t stat,
    output logic              in_ready,
    output logic              out_load,
    output qbr_pkg::dp_op_t   op
);
    import qbr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SETUP  = 5'b00010,
        ST_STEP_A = 5'b00100,
        ST_STEP_B = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    dp_op_t phase_reg, phase_next;

    function automatic dp_op_t next_phase(input dp_op_t p);
        dp_op_t n;
        unique case (p)
            OP_MUL_XEY: n = OP_MUL_YEX;
            OP_MUL_YEX: n = OP_MUL_EXX;
            OP_MUL_EXX: n = OP_MUL_EYY;
            OP_MUL_EYY: n = OP_MUL_XXX;
            OP_MUL_XXX: n = OP_MUL_YYY;
            OP_MUL_YYY: n = OP_SUM_Y;
            OP_SUM_Y:   n = OP_ORIENT;
            OP_ORIENT:  n = OP_MUL_XY;
            OP_MUL_XY:  n = OP_MUL_XS;
            OP_MUL_XS:  n = OP_MUL_YS;
            OP_MUL_YS:  n = OP_MUL_CVX;
            OP_MUL_CVX: n = OP_MUL_CVY;
            OP_MUL_CVY: n = OP_DY;
            OP_DY:      n = OP_FINISH;
            default:    n = OP_NOP;
        endcase
        return n;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        op         = OP_NOP;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_func == FUNC_START)
                    begin
                        op         = OP_LOAD;
                        phase_next = OP_MUL_XEY;
                        state_next = ST_SETUP;
                    end
                    else if (stat.active)
                    begin
                        state_next = ST_STEP_A;
                    end
                    else
                    begin
                        op         = OP_IDLE_STEP;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SETUP:
            begin
                phase_next = next_phase(phase_reg);
                if (phase_reg == OP_ORIENT && stat.cv_zero)
                begin
                    op         = OP_STRAIGHT;
                    state_next = ST_EMIT;
                end
                else
                begin
                    op = phase_reg;
                    if (phase_reg == OP_FINISH)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_STEP_A:
            begin
                op         = OP_STEP_A;
                state_next = stat.at_stop ? ST_EMIT : ST_STEP_B;
            end
            ST_STEP_B:
            begin
                op         = OP_STEP_B;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register frees up
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= OP_NOP;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== rtl/qbr_dp.sv =====
module qbr_dp #(
    parameter int COORD_BITS = qbr_pkg::COORD_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  qbr_pkg::dp_op_t   op,
    input  qbr_pkg::coord_t   start_x,
    input  qbr_pkg::coord_t   start_y,
    input  qbr_pkg::coord_t   ctrl_x,
    input  qbr_pkg::coord_t   ctrl_y,
    input  qbr_pkg::coord_t   end_x,
    input  qbr_pkg::coord_t   end_y,
    output qbr_pkg::dp_stat_t stat,
    output qbr_pkg::coord_t   res_x,
    output qbr_pkg::coord_t   res_y,
    output qbr_pkg::status_t  res_status
);
    import qbr_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int DW  = C + 1;
    localparam int SW  = C + 3;
    localparam int CVW = 2 * C + 4;
    localparam int PW  = CVW + SW;

    typedef logic signed [ACC_W-1:0] acc_t;

    logic signed [C-1:0]   p0x_reg, p0y_reg, p1x_reg, p1y_reg, p2x_reg, p2y_reg;
    logic signed [CVW-1:0] t0_reg, t1_reg, cv_reg;
    logic signed [SW-1:0]  xs_reg, ys_reg;
    logic signed [PW-1:0]  prod_reg;
    logic                  flip_reg;
    acc_t                  sxx_reg, syy_reg, sxy_reg, fdx_reg, fdy_reg, err_reg, dya_reg;
    logic signed [C-1:0]   cur_x_reg, cur_y_reg, stop_x_reg, stop_y_reg;
    logic                  xneg_reg, yneg_reg, dox_reg, doy_reg;
    logic                  active_reg, active_next;
    coord_t                res_x_reg, res_y_reg;
    status_t               res_status_reg;

    logic signed [DW-1:0]  exd, eyd, xxd, yyd;
    logic signed [CVW-1:0] mul_a;
    logic signed [SW-1:0]  mul_b;
    acc_t                  prod64, prod_fl;

    logic                  swap, sxn, syn, flip;
    logic signed [C-1:0]   nx0, nx2, ny0, ny2;
    logic signed [SW-1:0]  sumx, sumy;
    logic signed [CVW-1:0] cv_sw;
    logic signed [DW-1:0]  bx, by;

    acc_t                  e2, dya, fdx_b, fdy_b;
    logic                  do_x, do_y, at_stop, abort;
    logic signed [C-1:0]   cur_x_step, cur_y_step;

    assign exd = DW'(p2x_reg) - DW'(p1x_reg);
    assign eyd = DW'(p2y_reg) - DW'(p1y_reg);
    assign xxd = DW'(p0x_reg) - DW'(p1x_reg);
    assign yyd = DW'(p0y_reg) - DW'(p1y_reg);

    assign prod64  = ACC_W'(prod_reg);
    assign prod_fl = flip_reg ? -prod64 : prod64;

    // orientation: longer part first, step signs, curvature sign fix
    assign swap  = t0_reg > t1_reg;
    assign nx0   = swap ? p2x_reg : p0x_reg;
    assign nx2   = swap ? p0x_reg : p2x_reg;
    assign ny0   = swap ? p2y_reg : p0y_reg;
    assign ny2   = swap ? p0y_reg : p2y_reg;
    assign sxn   = !(nx0 < nx2);
    assign syn   = !(ny0 < ny2);
    assign sumx  = SW'(xxd) + SW'(exd);
    assign sumy  = SW'(yyd) + SW'(eyd);
    assign cv_sw = swap ? -cv_reg : cv_reg;
    assign flip  = cv_sw[CVW-1] ^ (sxn ^ syn);

    assign bx = yneg_reg ? (DW'(p0x_reg) - DW'(p1x_reg)) : (DW'(p1x_reg) - DW'(p0x_reg));
    assign by = xneg_reg ? (DW'(p1y_reg) - DW'(p0y_reg)) : (DW'(p0y_reg) - DW'(p1y_reg));

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_MUL_XEY: begin mul_a = CVW'(xxd);    mul_b = SW'(eyd); end
            OP_MUL_YEX: begin mul_a = CVW'(yyd);    mul_b = SW'(exd); end
            OP_MUL_EXX: begin mul_a = CVW'(exd);    mul_b = SW'(exd); end
            OP_MUL_EYY: begin mul_a = CVW'(eyd);    mul_b = SW'(eyd); end
            OP_MUL_XXX: begin mul_a = CVW'(xxd);    mul_b = SW'(xxd); end
            OP_MUL_YYY: begin mul_a = CVW'(yyd);    mul_b = SW'(yyd); end
            OP_MUL_XY:  begin mul_a = CVW'(xs_reg); mul_b = ys_reg;   end
            OP_MUL_XS:  begin mul_a = CVW'(xs_reg); mul_b = xs_reg;   end
            OP_MUL_YS:  begin mul_a = CVW'(ys_reg); mul_b = ys_reg;   end
            OP_MUL_CVX: begin mul_a = cv_reg;       mul_b = SW'(bx);  end
            OP_MUL_CVY: begin mul_a = cv_reg;       mul_b = SW'(by);  end
            default:    begin mul_a = '0;           mul_b = '0;       end
        endcase
    end

    // one pixel step: both tests on the doubled error, then x and y moves
    assign at_stop = (cur_x_reg == stop_x_reg) && (cur_y_reg == stop_y_reg);
    assign e2      = err_reg <<< 1;
    assign do_y    = e2 < fdx_reg;
    assign do_x    = fdy_reg < e2;
    assign dya     = do_x ? fdy_reg + syy_reg : fdy_reg;
    assign fdx_b   = fdx_reg - (do_x ? sxy_reg : '0) + (do_y ? sxx_reg : '0);
    assign fdy_b   = dya - (do_y ? sxy_reg : '0);
    assign abort   = !(fdy_reg < fdx_reg);

    assign cur_x_step = xneg_reg ? cur_x_reg - C'(1) : cur_x_reg + C'(1);
    assign cur_y_step = yneg_reg ? cur_y_reg - C'(1) : cur_y_reg + C'(1);

    always_comb
    begin
        active_next = active_reg;
        case (op)
            OP_FINISH:   active_next = 1'b1;
            OP_STRAIGHT: active_next = 1'b0;
            OP_STEP_A:   active_next = at_stop ? 1'b0 : active_reg;
            OP_STEP_B:   active_next = abort ? 1'b0 : active_reg;
            default:     active_next = active_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (op)
            OP_IDLE_STEP:
            begin
                res_x_reg      <= '0;
                res_y_reg      <= '0;
                res_status_reg <= RS_IDLE;
            end
            OP_LOAD:
            begin
                p0x_reg <= start_x[C-1:0];
                p0y_reg <= start_y[C-1:0];
                p1x_reg <= ctrl_x[C-1:0];
                p1y_reg <= ctrl_y[C-1:0];
                p2x_reg <= end_x[C-1:0];
                p2y_reg <= end_y[C-1:0];
            end
            OP_MUL_YEX: t0_reg <= CVW'(prod_reg);
            OP_MUL_EXX: cv_reg <= t0_reg - CVW'(prod_reg);
            OP_MUL_EYY: t0_reg <= CVW'(prod_reg);
            OP_MUL_XXX: t0_reg <= t0_reg + CVW'(prod_reg);
            OP_MUL_YYY: t1_reg <= CVW'(prod_reg);
            OP_SUM_Y:   t1_reg <= t1_reg + CVW'(prod_reg);
            OP_ORIENT:
            begin
                p0x_reg  <= nx0;
                p2x_reg  <= nx2;
                p0y_reg  <= ny0;
                p2y_reg  <= ny2;
                xneg_reg <= sxn;
                yneg_reg <= syn;
                xs_reg   <= sxn ? -sumx : sumx;
                ys_reg   <= syn ? -sumy : sumy;
                cv_reg   <= flip ? -cv_sw : cv_sw;
                flip_reg <= flip;
            end
            OP_MUL_XS:  sxy_reg <= prod_fl <<< 1;
            OP_MUL_YS:  sxx_reg <= prod_fl;
            OP_MUL_CVX: syy_reg <= prod_fl;
            OP_MUL_CVY: fdx_reg <= (prod64 <<< 2) + sxx_reg - sxy_reg;
            OP_DY:      fdy_reg <= (prod64 <<< 2) + syy_reg - sxy_reg;
            OP_FINISH:
            begin
                err_reg        <= fdx_reg + fdy_reg + sxy_reg;
                sxx_reg        <= sxx_reg <<< 1;
                syy_reg        <= syy_reg <<< 1;
                cur_x_reg      <= p0x_reg;
                cur_y_reg      <= p0y_reg;
                stop_x_reg     <= p2x_reg;
                stop_y_reg     <= p2y_reg;
                res_x_reg      <= '0;
                res_y_reg      <= '0;
                res_status_reg <= RS_STARTED;
            end
            OP_STRAIGHT:
            begin
                res_x_reg      <= '0;
                res_y_reg      <= '0;
                res_status_reg <= RS_STRAIGHT;
            end
            OP_STEP_A:
            begin
                res_x_reg      <= IO_W'(cur_x_reg);
                res_y_reg      <= IO_W'(cur_y_reg);
                res_status_reg <= RS_END;
                if (!at_stop)
                begin
                    dox_reg <= do_x;
                    doy_reg <= do_y;
                    dya_reg <= dya;
                    fdx_reg <= fdx_b;
                    fdy_reg <= fdy_b;
                    if (do_x)
                    begin
                        cur_x_reg <= cur_x_step;
                    end
                    if (do_y)
                    begin
                        cur_y_reg <= cur_y_step;
                    end
                end
            end
            OP_STEP_B:
            begin
                err_reg        <= err_reg + (dox_reg ? dya_reg : '0) + (doy_reg ? fdx_reg : '0);
                res_status_reg <= abort ? RS_ABORT : RS_PIXEL;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.active  = active_reg;
    assign stat.cv_zero = (cv_reg == '0);
    assign stat.at_stop = at_stop;

    assign res_x      = res_x_reg;
    assign res_y      = res_y_reg;
    assign res_status = res_status_reg;

endmodule

// ===== rtl/quad_bezier_rasterizer_unit.sv =====
// channel  | direction | beat carries
// ---------+-----------+-----------------------------------------------
// item     | in        | func, start_x/y, ctrl_x/y, end_x/y
// result   | out       | pixel_x, pixel_y, status
//
// A start beat runs fifteen setup steps through one shared multiplier with a
// registered product, then the output load. A straight line ends at the
// orientation step. A step beat runs STEP_A and STEP_B for the gradient test
// and error update, then the output load; a step with no active curve goes
// straight to the output load; the final pixel at the end point skips STEP_B.
// Reset clears the controller and the active flag; the block then takes beats.
// A stalled result waits in the output register while the next beat is taken.
module quad_bezier_rasterizer_unit #(
    parameter int COORD_BITS = qbr_pkg::COORD_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    qbr_in_if.sink    item,
    qbr_out_if.source result
);
    import qbr_pkg::*;

    dp_op_t   op;
    dp_stat_t stat;
    logic     out_free, out_load;
    coord_t   res_x, res_y;
    status_t  res_status;

    logic     out_valid_reg;
    coord_t   out_x_reg, out_y_reg;
    status_t  out_status_reg;

    assign out_free = !out_valid_reg || result.ready;

    qbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_func  (item.func),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (item.ready),
        .out_load (out_load),
        .op       (op)
    );

    qbr_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .start_x    (item.start_x),
        .start_y    (item.start_y),
        .ctrl_x     (item.ctrl_x),
        .ctrl_y     (item.ctrl_y),
        .end_x      (item.end_x),
        .end_y      (item.end_y),
        .stat       (stat),
        .res_x      (res_x),
        .res_y      (res_y),
        .res_status (res_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_x_reg      <= res_x;
            out_y_reg      <= res_y;
            out_status_reg <= res_status;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.pixel_x = out_x_reg;
    assign result.pixel_y = out_y_reg;
    assign result.status  = out_status_reg;

endmodule
